### rtl/core/kct_pkg.sv
// kct_pkg: types, widths and opcodes shared by the keyed counter table.
// No dependencies; compile first.
package kct_pkg;

	localparam int ENTRIES    = 256;
	localparam int COUNT_BITS = 16;
	localparam int ID_BITS    = $clog2(ENTRIES);

	// fixed beat field widths
	localparam int OPC_W = 3;
	localparam int EID_W = 8;
	localparam int AMT_W = 16;
	localparam int CNT_W = 16;

	localparam int WIDE_W = (COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W;

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [ID_BITS-1:0]    idx_t;

	localparam cnt_t CNT_MAX = '1;

	typedef enum logic [OPC_W-1:0] {
		OP_QUERY = 3'd0,
		OP_INIT  = 3'd1,
		OP_SET   = 3'd2,
		OP_INC   = 3'd3,
		OP_DEC   = 3'd4,
		OP_RESET = 3'd5
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             in_range;
		logic             present;
		cnt_t             cnt;
		logic [AMT_W-1:0] amount;
		logic             invalidate;
	} upd_in_t;

	typedef struct packed {
		logic             wr_en;
		logic             set_present;
		cnt_t             new_cnt;
		logic             entry_valid;
		logic [CNT_W-1:0] count_value;
		logic             notify;
		logic             notify_invalidate;
	} upd_out_t;

endpackage

### rtl/core/kct_req_if.sv
// kct_req_if: request channel (valid/ready plus request payload).
// Depends on kct_pkg.
interface kct_req_if;
	import kct_pkg::*;

	logic             valid;
	logic             ready;
	logic [OPC_W-1:0] opcode;
	logic [EID_W-1:0] entry_id;
	logic [AMT_W-1:0] amount;
	logic             invalidate;

	modport source(output valid, opcode, entry_id, amount, invalidate, input ready);
	modport sink(input valid, opcode, entry_id, amount, invalidate, output ready);
endinterface

### rtl/core/kct_rsp_if.sv
// kct_rsp_if: response channel (valid/ready plus result payload).
// Depends on kct_pkg.
interface kct_rsp_if;
	import kct_pkg::*;

	logic             valid;
	logic             ready;
	logic             entry_valid;
	logic [CNT_W-1:0] count_value;
	logic             notify;
	logic             notify_invalidate;

	modport source(output valid, entry_valid, count_value, notify, notify_invalidate,
		input ready);
	modport sink(input valid, entry_valid, count_value, notify, notify_invalidate,
		output ready);
endinterface

### rtl/core/keyed_counter_table.sv
// Keyed counter table: 256 saturating 16-bit counters selected by entry_id,
// each guarded by a valid bit that reset clears; counts live in one RAM
// (kct_ram) and are read, updated and written back once per request beat.
// Throughput is one request per cycle while the response side takes beats;
// a request passes through the registered RAM read and then the update into
// the response register. A write to the entry read in the same cycle is
// forwarded. No clearing pass after reset.
// Depends on kct_pkg, kct_req_if, kct_rsp_if, kct_ram and kct_update.
module keyed_counter_table (
	input  logic clk,
	input  logic arst_n,
	kct_req_if.sink   req,
	kct_rsp_if.source rsp
);
	import kct_pkg::*;

	logic [ENTRIES-1:0] present_q;

	logic             s1_valid;
	op_t              op_s1;
	idx_t             id_s1;
	logic             in_range_s1;
	logic [AMT_W-1:0] amt_s1;
	logic             inval_s1;
	logic             fwd_hit_s1;
	cnt_t             fwd_data_s1;

	logic             out_valid_q;
	logic             entry_valid_q;
	logic [CNT_W-1:0] count_value_q;
	logic             notify_q;
	logic             notify_inval_q;

	logic     s1_fire;
	logic     accept;
	idx_t     req_idx;
	cnt_t     rdata;
	upd_in_t  upd_in;
	upd_out_t upd_out;

	assign s1_fire   = s1_valid && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid || s1_fire;
	assign accept    = req.valid && req.ready;
	assign req_idx   = ID_BITS'(req.entry_id);

	kct_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(ENTRIES)
	) u_cnt_ram (
		.clk  (clk),
		.we   (s1_fire && upd_out.wr_en),
		.waddr(id_s1),
		.wdata(upd_out.new_cnt),
		.re   (accept),
		.raddr(req_idx),
		.rdata(rdata)
	);

	always_comb begin
		upd_in.op         = op_s1;
		upd_in.in_range   = in_range_s1;
		upd_in.present    = present_q[id_s1];
		upd_in.cnt        = fwd_hit_s1 ? fwd_data_s1 : rdata;
		upd_in.amount     = amt_s1;
		upd_in.invalidate = inval_s1;
	end

	kct_update u_update (
		.upd_i(upd_in),
		.upd_o(upd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire && upd_out.set_present) begin
				present_q[id_s1] <= 1'b1;
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_fire) begin
				s1_valid <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_t'(req.opcode);
			id_s1       <= req_idx;
			in_range_s1 <= 32'(req.entry_id) < ENTRIES;
			amt_s1      <= req.amount;
			inval_s1    <= req.invalidate;
			fwd_hit_s1  <= s1_fire && upd_out.wr_en && (id_s1 == req_idx);
			fwd_data_s1 <= upd_out.new_cnt;
		end
		if (s1_fire) begin
			entry_valid_q  <= upd_out.entry_valid;
			count_value_q  <= upd_out.count_value;
			notify_q       <= upd_out.notify;
			notify_inval_q <= upd_out.notify_invalidate;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.entry_valid       = entry_valid_q;
	assign rsp.count_value       = count_value_q;
	assign rsp.notify            = notify_q;
	assign rsp.notify_invalidate = notify_inval_q;

	a_write_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && upd_out.wr_en |-> upd_out.set_present || present_q[id_s1])
		else $error("count written to an entry that is not valid");

	a_init_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && upd_out.set_present |=> present_q[$past(id_s1)])
		else $error("init did not mark entry valid");

	a_notify_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && upd_out.notify |-> upd_out.entry_valid && upd_out.wr_en)
		else $error("notification on an absent entry");

	a_absent_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !entry_valid_q |-> count_value_q == '0 && !notify_q)
		else $error("absent entry returned nonzero count or notification");
endmodule

### rtl/core/kct_ram.sv
// kct_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module kct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/core/kct_update.sv
// kct_update: modify step of the read-modify-write; opcode decode,
// saturating add/subtract and notification. Depends on kct_pkg.
module kct_update (
	input  kct_pkg::upd_in_t  upd_i,
	output kct_pkg::upd_out_t upd_o
);
	import kct_pkg::*;

	logic [WIDE_W-1:0]   amt_wide;
	cnt_t                amt;
	logic [COUNT_BITS:0] sum;
	cnt_t                c;
	logic                ntf;
	logic                wr;
	logic                setp;
	logic                vld;

	always_comb begin
		amt_wide = WIDE_W'(upd_i.amount);
		amt      = (amt_wide > WIDE_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(amt_wide);
		sum      = {1'b0, upd_i.cnt} + {1'b0, amt};
		c        = upd_i.cnt;
		ntf      = 1'b0;
		wr       = 1'b0;
		setp     = 1'b0;
		vld      = 1'b0;
		if (upd_i.in_range && upd_i.op == OP_INIT) begin
			c    = '0;
			wr   = 1'b1;
			setp = 1'b1;
			vld  = 1'b1;
		end else if (upd_i.in_range && upd_i.present) begin
			wr  = 1'b1;
			vld = 1'b1;
			unique case (upd_i.op)
				OP_SET: begin
					if (upd_i.cnt != amt) begin
						c   = amt;
						ntf = 1'b1;
					end
				end
				OP_INC: begin
					c   = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
					ntf = amt != '0;
				end
				OP_DEC: begin
					c   = (amt > upd_i.cnt) ? '0 : upd_i.cnt - amt;
					ntf = amt != '0;
				end
				OP_RESET: begin
					if (upd_i.cnt != '0) begin
						c   = '0;
						ntf = upd_i.invalidate;
					end
				end
				default: begin
					c = upd_i.cnt;
				end
			endcase
		end
	end

	always_comb begin
		upd_o.wr_en             = wr;
		upd_o.set_present       = setp;
		upd_o.new_cnt           = c;
		upd_o.entry_valid       = vld;
		upd_o.count_value       = vld ? CNT_W'(WIDE_W'(c)) : '0;
		upd_o.notify            = ntf;
		upd_o.notify_invalidate = ntf & upd_i.invalidate;
	end
endmodule
